// ===== rtl/core/mfqs_pkg.sv =====
// ============================================================================
// mfqs_pkg
// Shared types and codes for the multilevel feedback queue scheduler.
// ============================================================================
`default_nettype none

package mfqs_pkg;

    // Fixed field widths
    localparam int ID_W  = 6;
    localparam int LVL_W = 2;
    localparam int OP_W  = 2;
    localparam int OC_W  = 2;
    localparam int ST_W  = 2;

    // Default sizing
    localparam int DEF_LEVELS      = 4;
    localparam int DEF_MAX_THREADS = 64;

    // Opcodes
    localparam logic [OP_W-1:0] OP_ADMIT  = 2'd0;
    localparam logic [OP_W-1:0] OP_PICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_RETURN = 2'd2;

    // Return outcomes (any other code means finished)
    localparam logic [OC_W-1:0] OC_QUANTUM = 2'd0;
    localparam logic [OC_W-1:0] OC_YIELD   = 2'd1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_STATE = 2'd3;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]  opcode;
        logic [ID_W-1:0]  thr_id;
        logic [LVL_W-1:0] level;
        logic [OC_W-1:0]  outcome;
    } t_in_word;

    // Output word
    typedef struct packed {
        logic [ID_W-1:0]  chosen_id;
        logic [LVL_W-1:0] chosen_level;
        logic [ST_W-1:0]  status;
    } t_out_word;

    // Result of one execute step; from_mem takes the id from the queue read
    typedef struct packed {
        logic [ID_W-1:0]  chosen_id;
        logic [LVL_W-1:0] chosen_level;
        logic [ST_W-1:0]  status;
        logic             from_mem;
    } t_exec_res;

endpackage

`default_nettype wire

// ===== rtl/core/mfqs_ram.sv =====
// ============================================================================
// mfqs_ram
// Queue entry storage: one write port, one read port, registered read data.
// ============================================================================
`default_nettype none

module mfqs_ram #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_we,
    input  wire logic [ADDR_W-1:0]         i_waddr,
    input  wire logic [mfqs_pkg::ID_W-1:0] i_wdata,
    input  wire logic                      i_re,
    input  wire logic [ADDR_W-1:0]         i_raddr,
    output logic      [mfqs_pkg::ID_W-1:0] o_rdata
);
    import mfqs_pkg::*;

    logic [ID_W-1:0] r_mem [DEPTH];
    logic [ID_W-1:0] r_rdata;

    // Write entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read entry; hold data until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/mfqs_engine.sv =====
// ============================================================================
// mfqs_engine
// Queue pointers, level counts and running-thread state; executes one word.
// ============================================================================
`default_nettype none

module mfqs_engine #(
    parameter int LEVELS      = mfqs_pkg::DEF_LEVELS,
    parameter int MAX_THREADS = mfqs_pkg::DEF_MAX_THREADS,
    parameter int LW          = (LEVELS > 1) ? $clog2(LEVELS) : 1,
    parameter int PW          = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_fire,
    input  wire mfqs_pkg::t_in_word        i_item,
    input  wire logic [mfqs_pkg::ID_W-1:0] i_run_id,
    output logic                           o_mem_we,
    output logic      [LW+PW-1:0]          o_mem_waddr,
    output logic      [mfqs_pkg::ID_W-1:0] o_mem_wdata,
    output logic                           o_mem_re,
    output logic      [LW+PW-1:0]          o_mem_raddr,
    output mfqs_pkg::t_exec_res            o_res
);
    import mfqs_pkg::*;

    localparam int CW = $clog2(MAX_THREADS + 1);

    logic [PW-1:0] r_head [LEVELS];
    logic [PW-1:0] r_tail [LEVELS];
    logic [CW-1:0] r_cnt  [LEVELS];
    logic [PW-1:0] n_head [LEVELS];
    logic [PW-1:0] n_tail [LEVELS];
    logic [CW-1:0] n_cnt  [LEVELS];
    logic          r_run_vld, n_run_vld;
    logic [LW-1:0] r_run_lvl, n_run_lvl;

    logic          pick_hit;
    logic [LW-1:0] pick_lvl;
    logic [LW-1:0] adm_lvl;
    logic [LW-1:0] ret_lvl;
    logic [LW-1:0] push_lvl;
    logic [LW-1:0] cnt_lvl;
    logic [CW-1:0] cnt_sel;
    logic          push_full;
    logic [PW-1:0] tail_sel;
    logic [PW-1:0] head_sel;
    logic [PW-1:0] tail_nxt;
    logic [PW-1:0] head_nxt;
    logic          finished;

    // Find the lowest-numbered non-empty level
    always_comb begin
        pick_hit = 1'b0;
        pick_lvl = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (r_cnt[i] != '0) begin
                pick_hit = 1'b1;
                pick_lvl = LW'(i);
            end
        end
    end

    // Saturate the admit level, work out the re-queue level
    always_comb begin
        if (int'(i_item.level) >= LEVELS) begin
            adm_lvl = LW'(LEVELS - 1);
        end else begin
            adm_lvl = LW'(i_item.level);
        end
        if (i_item.outcome == OC_QUANTUM && r_run_lvl != LW'(LEVELS - 1)) begin
            ret_lvl = r_run_lvl + LW'(1);
        end else begin
            ret_lvl = r_run_lvl;
        end
    end

    assign finished  = (i_item.outcome != OC_QUANTUM) && (i_item.outcome != OC_YIELD);
    assign push_lvl  = (i_item.opcode == OP_ADMIT) ? adm_lvl : ret_lvl;
    assign cnt_lvl   = (i_item.opcode == OP_PICK) ? pick_lvl : push_lvl;
    assign cnt_sel   = r_cnt[cnt_lvl];
    assign push_full = (cnt_sel == CW'(MAX_THREADS));
    assign tail_sel  = r_tail[push_lvl];
    assign head_sel  = r_head[pick_lvl];
    assign tail_nxt  = (tail_sel == PW'(MAX_THREADS - 1)) ? '0 : tail_sel + PW'(1);
    assign head_nxt  = (head_sel == PW'(MAX_THREADS - 1)) ? '0 : head_sel + PW'(1);

    // Execute one word
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_run_vld   = r_run_vld;
        n_run_lvl   = r_run_lvl;
        o_mem_we    = 1'b0;
        o_mem_waddr = {push_lvl, tail_sel};
        o_mem_wdata = i_item.thr_id;
        o_mem_re    = 1'b0;
        o_mem_raddr = {pick_lvl, head_sel};
        o_res       = '0;
        if (i_fire) begin
            unique case (i_item.opcode)
                OP_ADMIT: begin
                    if (push_full) begin
                        o_res.status = ST_FULL;
                    end else begin
                        o_mem_we              = 1'b1;
                        n_tail[push_lvl]      = tail_nxt;
                        n_cnt[push_lvl]       = cnt_sel + CW'(1);
                        o_res.chosen_id       = i_item.thr_id;
                        o_res.chosen_level    = LVL_W'(push_lvl);
                    end
                end
                OP_PICK: begin
                    if (r_run_vld) begin
                        o_res.status = ST_STATE;
                    end else if (!pick_hit) begin
                        o_res.status = ST_EMPTY;
                    end else begin
                        o_mem_re              = 1'b1;
                        n_head[pick_lvl]      = head_nxt;
                        n_cnt[pick_lvl]       = cnt_sel - CW'(1);
                        n_run_vld             = 1'b1;
                        n_run_lvl             = pick_lvl;
                        o_res.chosen_level    = LVL_W'(pick_lvl);
                        o_res.from_mem        = 1'b1;
                    end
                end
                OP_RETURN: begin
                    if (!r_run_vld) begin
                        o_res.status = ST_STATE;
                    end else if (finished) begin
                        n_run_vld             = 1'b0;
                        o_res.chosen_id       = i_run_id;
                        o_res.chosen_level    = LVL_W'(r_run_lvl);
                    end else if (push_full) begin
                        o_res.status = ST_FULL;
                    end else begin
                        o_mem_we              = 1'b1;
                        o_mem_wdata           = i_run_id;
                        n_tail[push_lvl]      = tail_nxt;
                        n_cnt[push_lvl]       = cnt_sel + CW'(1);
                        n_run_vld             = 1'b0;
                        o_res.chosen_id       = i_run_id;
                        o_res.chosen_level    = LVL_W'(push_lvl);
                    end
                end
                default: begin
                    o_res = '0;
                end
            endcase
        end
    end

    // Update queue state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVELS; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_cnt[i]  <= '0;
            end
            r_run_vld <= 1'b0;
            r_run_lvl <= '0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_cnt     <= n_cnt;
            r_run_vld <= n_run_vld;
            r_run_lvl <= n_run_lvl;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/multilevel_feedback_queue_scheduler.sv =====
// ============================================================================
// multilevel_feedback_queue_scheduler
// One FIFO of thread ids per priority level with admit, pick and return.
// ============================================================================
//
//   Channel  Valid     Ready     Word
//   -------  --------  --------  -----------------------
//   request  i_valid   o_ready   i_data  (t_in_word)
//   result   o_valid   i_ready   o_data  (t_out_word)
//
// A word sits in the input register while it executes against the queue
// state; its result shows on o_valid at the next edge, and one word can
// enter per cycle while the result register is free or draining. The queue
// entry read for a pick lands in the memory read register at the same edge
// as the result. Reset clears pointers, counts and the running state at
// once; the queue memory is not cleared. A held result stalls only the
// input register, which still takes one more word.
// ============================================================================
`default_nettype none

module multilevel_feedback_queue_scheduler #(
    parameter int LEVELS      = mfqs_pkg::DEF_LEVELS,
    parameter int MAX_THREADS = mfqs_pkg::DEF_MAX_THREADS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire mfqs_pkg::t_in_word   i_data,
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output mfqs_pkg::t_out_word       o_data
);
    import mfqs_pkg::*;

    localparam int LW     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int PW     = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int ADDR_W = LW + PW;
    localparam int DEPTH  = LEVELS * (2 ** PW);

    logic              r_in_vld;
    t_in_word          r_in;
    logic              r_out_vld;
    t_exec_res         r_res;
    logic              exec_fire;
    t_exec_res         exec_res;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [ID_W-1:0]   mem_wdata;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ID_W-1:0]   mem_rdata;

    // Execute when the result register is free or draining
    assign exec_fire = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready   = !r_in_vld || exec_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_ready) begin
            r_in_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_data;
        end
    end

    mfqs_engine #(
        .LEVELS      (LEVELS),
        .MAX_THREADS (MAX_THREADS),
        .LW          (LW),
        .PW          (PW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (exec_fire),
        .i_item      (r_in),
        .i_run_id    (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .o_res       (exec_res)
    );

    mfqs_ram #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (exec_fire) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            r_res <= exec_res;
        end
    end

    // Take the picked id from the read register; it holds while the result waits
    assign o_valid             = r_out_vld;
    assign o_data.chosen_id    = r_res.from_mem ? mem_rdata : r_res.chosen_id;
    assign o_data.chosen_level = r_res.chosen_level;
    assign o_data.status       = r_res.status;

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// ============================================================================
// tb_top
// Self-checking bench for the multilevel feedback queue scheduler: a queue of
// request words feeds a clocked driver, a clocked monitor checks each result
// word against a scheduler model kept in step with every accepted request.
// ============================================================================
`timescale 1ns / 1ps

module tb_top;

    import mfqs_pkg::*;

    localparam int LEVELS      = DEF_LEVELS;
    localparam int MAX_THREADS = DEF_MAX_THREADS;
    localparam int ITEM_TARGET = 1300;

    // Codes the package leaves unnamed
    localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
    localparam logic [OC_W-1:0] OC_FINISH     = 2'd2;
    localparam logic [OC_W-1:0] OC_FINISH_ALT = 2'd3;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_word  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_word o_data;

    // Requests waiting for the driver, results waiting for the monitor
    t_in_word  pending_words[$];
    t_out_word expected_results[$];

    // Scheduler model state
    logic [ID_W-1:0]  sched_store [LEVELS][MAX_THREADS];
    int               head_ptr    [LEVELS];
    int               tail_ptr    [LEVELS];
    int               level_cnt   [LEVELS];
    logic [ID_W-1:0]  run_id;
    logic [LVL_W-1:0] run_lvl;
    logic             run_active;

    int err_count = 0;
    int req_gap   = 0;
    int rsp_stall = 0;
    bit req_calm  = 1'b0;
    bit rsp_calm  = 1'b0;

    multilevel_feedback_queue_scheduler #(
        .LEVELS      (LEVELS),
        .MAX_THREADS (MAX_THREADS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always #1 i_clk = ~i_clk;

    // Append a thread at the tail of a level; refuse when the level is full
    function automatic bit level_append(int lv, logic [ID_W-1:0] id);
        if (level_cnt[lv] >= MAX_THREADS) return 1'b0;
        sched_store[lv][tail_ptr[lv]] = id;
        tail_ptr[lv] = (tail_ptr[lv] + 1) % MAX_THREADS;
        level_cnt[lv]++;
        return 1'b1;
    endfunction

    // Advance the model by one request word and return its result word
    function automatic t_out_word predict_schedule(t_in_word w);
        t_out_word r;
        int        lv;
        int        target;
        r  = '0;
        lv = int'(w.level);
        case (w.opcode)
            OP_ADMIT: begin
                if (lv >= LEVELS) lv = LEVELS - 1;
                if (level_append(lv, w.thr_id)) begin
                    r.chosen_id    = w.thr_id;
                    r.chosen_level = LVL_W'(lv);
                    r.status       = ST_OK;
                end else begin
                    r.status = ST_FULL;
                end
            end
            OP_PICK: begin
                if (run_active) begin
                    r.status = ST_STATE;
                end else begin
                    r.status = ST_EMPTY;
                    for (int i = 0; i < LEVELS; i++) begin
                        if (level_cnt[i] != 0 && r.status == ST_EMPTY) begin
                            run_id      = sched_store[i][head_ptr[i]];
                            head_ptr[i] = (head_ptr[i] + 1) % MAX_THREADS;
                            level_cnt[i]--;
                            run_lvl        = LVL_W'(i);
                            run_active     = 1'b1;
                            r.chosen_id    = run_id;
                            r.chosen_level = LVL_W'(i);
                            r.status       = ST_OK;
                        end
                    end
                end
            end
            OP_RETURN: begin
                if (!run_active) begin
                    r.status = ST_STATE;
                end else if (w.outcome != OC_QUANTUM && w.outcome != OC_YIELD) begin
                    run_active     = 1'b0;
                    r.chosen_id    = run_id;
                    r.chosen_level = run_lvl;
                    r.status       = ST_OK;
                end else begin
                    target = int'(run_lvl);
                    if (w.outcome == OC_QUANTUM && target + 1 < LEVELS) target++;
                    if (level_append(target, run_id)) begin
                        run_active     = 1'b0;
                        r.chosen_id    = run_id;
                        r.chosen_level = LVL_W'(target);
                        r.status       = ST_OK;
                    end else begin
                        r.status = ST_FULL;
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    task automatic push_word(logic [OP_W-1:0] op, int id, int lv, logic [OC_W-1:0] oc);
        t_in_word w;
        w.opcode  = op;
        w.thr_id  = ID_W'(id);
        w.level   = LVL_W'(lv);
        w.outcome = oc;
        pending_words.push_back(w);
    endtask

    // Drive request words; hold valid and the word until accepted
    always @(posedge i_clk) begin : drive_req
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_schedule(pending_words.pop_front()));
                if ($urandom_range(0, 63) == 0) req_calm = !req_calm;
                req_gap = req_calm ? 0 : $urandom_range(0, 6);
            end
            if (i_valid && !o_ready) begin
                // keep the current word on the bus
            end else if (req_gap > 0) begin
                req_gap--;
                i_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                i_valid <= 1'b1;
                i_data  <= pending_words[0];
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Check result words against the oldest expectation; stall at random
    always @(posedge i_clk) begin : watch_rsp
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result word: id=%0d lvl=%0d st=%0d",
                                 o_data.chosen_id, o_data.chosen_level, o_data.status);
                end else begin
                    exp_w = expected_results.pop_front();
                    if (o_data.chosen_id !== exp_w.chosen_id ||
                        o_data.chosen_level !== exp_w.chosen_level ||
                        o_data.status !== exp_w.status) begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch id/lvl/st: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     exp_w.chosen_id, exp_w.chosen_level, exp_w.status,
                                     o_data.chosen_id, o_data.chosen_level, o_data.status);
                    end
                end
                if ($urandom_range(0, 63) == 0) rsp_calm = !rsp_calm;
                rsp_stall = rsp_calm ? 0 : $urandom_range(0, 6);
            end
            if (rsp_stall > 0) begin
                rsp_stall--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Build the stimulus, release reset, wait for the last result
    initial begin : run_test
        int kind;
        int n;
        int lv;

        for (int i = 0; i < LEVELS; i++) begin
            head_ptr[i]  = 0;
            tail_ptr[i]  = 0;
            level_cnt[i] = 0;
        end
        run_id     = '0;
        run_lvl    = '0;
        run_active = 1'b0;

        // Directed: empty pick, idle return, unused opcode, then a walk
        // through demotion, yield, both finish codes and the lowest level
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_YIELD);
        push_word(OP_UNUSED, 63, 3, OC_FINISH_ALT);
        push_word(OP_ADMIT,  63, 3, OC_QUANTUM);
        push_word(OP_ADMIT,  0,  0, OC_QUANTUM);
        push_word(OP_ADMIT,  42, 1, OC_QUANTUM);
        push_word(OP_ADMIT,  21, 2, OC_QUANTUM);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_QUANTUM);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_YIELD);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_FINISH);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_FINISH_ALT);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_QUANTUM);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_QUANTUM);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_FINISH);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);
        push_word(OP_RETURN, 0,  0, OC_FINISH);
        push_word(OP_PICK,   0,  0, OC_QUANTUM);

        // Random: mostly pick/return pairs and admits, with drains, fills
        // that push a level to full under a running thread, and noise
        while (pending_words.size() < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                push_word(OP_PICK, $urandom_range(0, 63), $urandom_range(0, 3),
                          OC_W'($urandom_range(0, 3)));
                push_word(OP_RETURN, $urandom_range(0, 63), $urandom_range(0, 3),
                          OC_W'($urandom_range(0, 3)));
            end else if (kind < 65) begin
                n = $urandom_range(1, 4);
                repeat (n) push_word(OP_ADMIT, $urandom_range(0, 63),
                                     $urandom_range(0, 3), OC_W'($urandom_range(0, 3)));
            end else if (kind < 74) begin
                n = $urandom_range(4, 40);
                repeat (n) begin
                    push_word(OP_PICK, 0, 0, OC_QUANTUM);
                    push_word(OP_RETURN, $urandom_range(0, 63), $urandom_range(0, 3),
                              $urandom_range(0, 1) ? OC_FINISH : OC_FINISH_ALT);
                end
            end else if (kind < 78) begin
                lv = $urandom_range(0, 3);
                push_word(OP_PICK, 0, 0, OC_QUANTUM);
                repeat (MAX_THREADS + 2) push_word(OP_ADMIT, $urandom_range(0, 63), lv,
                                                   OC_W'($urandom_range(0, 3)));
                push_word(OP_RETURN, 0, 0, $urandom_range(0, 1) ? OC_QUANTUM : OC_YIELD);
                push_word(OP_RETURN, 0, 0, OC_FINISH);
            end else if (kind < 90) begin
                push_word(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                          $urandom_range(0, 3), OC_W'($urandom_range(0, 3)));
            end else begin
                push_word(OP_PICK, 0, 0, OC_QUANTUM);
                push_word(OP_PICK, $urandom_range(0, 63), $urandom_range(0, 3),
                          OC_W'($urandom_range(0, 3)));
                push_word(OP_RETURN, 0, 0, OC_W'($urandom_range(0, 3)));
                push_word(OP_RETURN, 0, 0, OC_W'($urandom_range(0, 3)));
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_words.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_count == 0 && expected_results.size() == 0) begin
            $display("[multilevel_feedback_queue_scheduler] OK");
        end else begin
            $display("[multilevel_feedback_queue_scheduler] ERROR");
        end
        $finish;
    end

    // Stop a hung run
    initial begin : watchdog
        #1_000_000;
        $display("[multilevel_feedback_queue_scheduler] ERROR");
        $finish;
    end

endmodule

// ===== multilevel_feedback_queue_scheduler.f =====
rtl/core/mfqs_pkg.sv
rtl/core/mfqs_ram.sv
rtl/core/mfqs_engine.sv
rtl/core/multilevel_feedback_queue_scheduler.sv
bench/tb_top.sv
